/* sv/msa_pkg.sv */
`default_nettype none
package msa_pkg;
   localparam logic [63:0] PAGE_MASK = 64'h0000_0000_0000_0fff;
   localparam logic [63:0] LIMIT32   = 64'h0000_0000_ffff_ffff;
   localparam logic [30:0] KEND_RESET = 31'h0010_0000;
   localparam logic [31:0] TYPE_RAM  = 32'd1;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] rtype;
      logic [31:0] attr;
   } rec_type;

   typedef struct packed {
      rec_type rec;
      logic    last;
   } qent_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;
endpackage
`default_nettype wire

/* sv/msa_sorter.sv */
`default_nettype none
// insertion chain: each cell holds one record, new record shifts larger ones down
module msa_sorter #(
   parameter int MAX_RECORDS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire msa_pkg::rec_type  in_rec,
   input  wire logic              in_last,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output msa_pkg::qent_type      q_data
);
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

   msa_pkg::rec_type cell_ff [MAX_RECORDS];
   msa_pkg::rec_type cell_in [MAX_RECORDS];
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rd_ff, rd_in;
   msa_pkg::state_type state_ff, state_in;
   logic [MAX_RECORDS-1:0] gt;
   logic take;

   assign in_ready = (state_ff == msa_pkg::ST_LOAD);
   assign take = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < MAX_RECORDS; i++) begin
         gt[i] = (CW'(i) < count_ff) && (cell_ff[i].base > in_rec.base);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RECORDS; i++) begin
         cell_in[i] = cell_ff[i];
         if (take && count_ff < CW'(MAX_RECORDS)) begin
            if (i == 0) begin
               if (gt[0] || count_ff == '0) cell_in[0] = in_rec;
            end else if (gt[i]) begin
               cell_in[i] = gt[i-1] ? cell_ff[i-1] : in_rec;
            end else if (CW'(i) == count_ff) begin
               cell_in[i] = gt[i-1] ? cell_ff[i-1] : in_rec;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      case (state_ff)
         msa_pkg::ST_LOAD: begin
            if (take) begin
               if (count_ff < CW'(MAX_RECORDS)) count_in = count_ff + 1'b1;
               if (in_last) begin
                  state_in = msa_pkg::ST_DRAIN;
                  rd_in = '0;
               end
            end
         end
         msa_pkg::ST_DRAIN: begin
            if (count_ff == '0) begin
               state_in = msa_pkg::ST_LOAD;
            end else if (q_ready) begin
               if (CW'(rd_ff) + 1'b1 == count_ff) begin
                  state_in = msa_pkg::ST_LOAD;
                  count_in = '0;
               end else begin
                  rd_in = rd_ff + 1'b1;
               end
            end
         end
         default: state_in = msa_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      q_valid = (state_ff == msa_pkg::ST_DRAIN) && (count_ff != '0);
      q_data.rec  = cell_ff[rd_ff];
      q_data.last = (CW'(rd_ff) + 1'b1 == count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msa_pkg::ST_LOAD;
         count_ff <= '0;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
      cell_ff <= cell_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("count overflow");
   a_noload: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> !in_ready) else $error("load during drain");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready && q_data.last) |=> in_ready) else $error("no return to load");
endmodule
`default_nettype wire

/* sv/msa_fixer.sv */
`default_nettype none
// two-stage fix: kernel clip, then page alignment and usable calc, output register
module msa_fixer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [30:0]        kernel_end,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire msa_pkg::qent_type  q_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_out_base,
   output logic [63:0]             rsp_out_length,
   output logic [31:0]             rsp_out_type,
   output logic [31:0]             rsp_out_attr,
   output logic                    rsp_usable,
   output logic [31:0]             rsp_usable_length,
   output logic                    rsp_run_end
);
   // stage 1: clip
   logic s1_valid_ff, s1_ready;
   logic [63:0] s1_base_ff, s1_len_ff, s1_base_in, s1_len_in;
   logic s1_gone_ff, s1_gone_in;
   logic [31:0] s1_type_ff, s1_attr_ff;
   logic s1_last_ff;
   logic [63:0] kend, kdiff;

   assign kend = {33'd0, kernel_end};
   assign kdiff = kend - q_data.rec.base;

   always_comb begin
      s1_base_in = q_data.rec.base;
      s1_len_in  = q_data.rec.length;
      s1_gone_in = 1'b0;
      if (q_data.rec.base < kend) begin
         s1_base_in = kend;
         if (q_data.rec.length < kdiff) begin
            s1_len_in  = '0;
            s1_gone_in = 1'b1;
         end else begin
            s1_len_in = q_data.rec.length - kdiff;
         end
      end
   end

   assign q_ready = !s1_valid_ff || s1_ready;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (q_ready) s1_valid_ff <= q_valid;
      if (q_ready && q_valid) begin
         s1_base_ff <= s1_base_in;
         s1_len_ff  <= s1_len_in;
         s1_gone_ff <= s1_gone_in;
         s1_type_ff <= q_data.rec.rtype;
         s1_attr_ff <= q_data.rec.attr;
         s1_last_ff <= q_data.last;
      end
   end

   // stage 2: align
   logic [63:0] b2, l2, adiff, lsum;
   logic [64:0] gsum;
   logic use2;
   logic [31:0] ulen2;
   logic [63:0] room;

   always_comb begin
      b2 = s1_base_ff;
      l2 = s1_len_ff;
      adiff = '0;
      gsum = '0;
      lsum = '0;
      if (!s1_gone_ff && (((s1_base_ff | s1_len_ff) & msa_pkg::PAGE_MASK) != '0)) begin
         if (s1_type_ff == msa_pkg::TYPE_RAM) begin
            adiff = (64'h1000 - (s1_base_ff & msa_pkg::PAGE_MASK)) & msa_pkg::PAGE_MASK;
            b2 = (s1_base_ff + msa_pkg::PAGE_MASK) & ~msa_pkg::PAGE_MASK;
            lsum = (s1_len_ff >= adiff) ? s1_len_ff - adiff : '0;
            l2 = lsum & ~msa_pkg::PAGE_MASK;
         end else begin
            adiff = s1_base_ff & msa_pkg::PAGE_MASK;
            b2 = s1_base_ff & ~msa_pkg::PAGE_MASK;
            gsum = {1'b0, s1_len_ff} + {1'b0, adiff} + {1'b0, msa_pkg::PAGE_MASK};
            l2 = gsum[64] ? ~msa_pkg::PAGE_MASK : (gsum[63:0] & ~msa_pkg::PAGE_MASK);
         end
      end
      room = msa_pkg::LIMIT32 - b2;
      use2 = (s1_type_ff == msa_pkg::TYPE_RAM) && (l2 != '0) && (b2 <= msa_pkg::LIMIT32);
      ulen2 = '0;
      if (use2) ulen2 = (l2 > room) ? room[31:0] : l2[31:0];
   end

   assign s1_ready = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (s1_ready) rsp_valid <= s1_valid_ff;
      if (s1_ready && s1_valid_ff) begin
         rsp_out_base      <= b2;
         rsp_out_length    <= l2;
         rsp_out_type      <= s1_type_ff;
         rsp_out_attr      <= s1_attr_ff;
         rsp_usable        <= use2;
         rsp_usable_length <= ulen2;
         rsp_run_end       <= s1_last_ff;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ready) |=> s1_valid_ff) else $error("stage 1 lost");
   a_use: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_usable) |-> rsp_usable_length == '0) else $error("ulen");
   a_ram: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_usable) |-> rsp_out_type == msa_pkg::TYPE_RAM) else $error("type");
endmodule
`default_nettype wire

/* sv/memory_map_sort_and_page_align.sv */
// memory map sorter and page aligner
// input channel req_*: one region record per transfer, req_is_final marks the
// last record of a map. records are kept base-sorted in a chain of insertion
// cells, one record accepted per cycle while loading; equal bases keep order.
// records past MAX_RECORDS are dropped.
// after the final record the cells drain in order, one per cycle, through a
// two-stage fixer (kernel clip, then page alignment) to the rsp_* register.
// results: one per stored record, rsp_run_end on the last; each passes the
// stage-1 and rsp_* registers, one per cycle while rsp_ready is high.
// req_ready is low while a map drains; a stall on rsp_ready holds the chain.
// csr_write sets kernel_end (31 bits); write it only while the block is idle.
// reset: empty map, kernel_end = 0x100000, no result pending.
`default_nettype none
module memory_map_sort_and_page_align #(
   parameter int MAX_RECORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [30:0] csr_kernel_end,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_region_base,
   input  wire logic [63:0] req_region_length,
   input  wire logic [31:0] req_region_type,
   input  wire logic [31:0] req_region_attr,
   input  wire logic        req_is_final,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_out_base,
   output logic [63:0]      rsp_out_length,
   output logic [31:0]      rsp_out_type,
   output logic [31:0]      rsp_out_attr,
   output logic             rsp_usable,
   output logic [31:0]      rsp_usable_length,
   output logic             rsp_run_end
);
   logic [30:0] kend_ff;
   msa_pkg::rec_type in_rec;
   msa_pkg::qent_type q_data;
   logic q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) kend_ff <= msa_pkg::KEND_RESET;
      else if (csr_write) kend_ff <= csr_kernel_end;
   end

   assign in_rec.base   = req_region_base;
   assign in_rec.length = req_region_length;
   assign in_rec.rtype  = req_region_type;
   assign in_rec.attr   = req_region_attr;

   msa_sorter #(.MAX_RECORDS(MAX_RECORDS)) u_sorter (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_rec, .in_last(req_is_final),
      .q_valid, .q_ready, .q_data
   );

   msa_fixer u_fixer (
      .clock, .reset, .kernel_end(kend_ff),
      .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_out_base, .rsp_out_length, .rsp_out_type,
      .rsp_out_attr, .rsp_usable, .rsp_usable_length, .rsp_run_end
   );
endmodule
`default_nettype wire

/* dv/memory_map_checker.sv */
`default_nettype none
module memory_map_checker #(
   parameter int MAX_RECORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [30:0] csr_kernel_end,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [63:0] req_region_base,
   input  wire logic [63:0] req_region_length,
   input  wire logic [31:0] req_region_type,
   input  wire logic [31:0] req_region_attr,
   input  wire logic        req_is_final,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [63:0] rsp_out_base,
   input  wire logic [63:0] rsp_out_length,
   input  wire logic [31:0] rsp_out_type,
   input  wire logic [31:0] rsp_out_attr,
   input  wire logic        rsp_usable,
   input  wire logic [31:0] rsp_usable_length,
   input  wire logic        rsp_run_end,
   output int               failures,
   output int               pending,
   output int               regions_checked,
   output int               maps_done,
   output int               dropped
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] rtype;
      logic [31:0] attr;
      logic        usable;
      logic [31:0] usable_length;
      logic        run_end;
   } fixed_region_type;

   msa_pkg::rec_type sorted_map[MAX_RECORDS];
   int               map_count;
   logic [30:0]      kernel_end;
   fixed_region_type fixed_regions[$];

   assign pending = fixed_regions.size();

   // kernel clip, then page alignment
   function automatic void align_region(input logic [63:0] b_in, input logic [63:0] l_in,
                                        input logic [31:0] t, input logic [30:0] kend,
                                        output logic [63:0] b, output logic [63:0] l);
      logic [63:0] k;
      logic [63:0] diff;
      k = {33'b0, kend};
      b = b_in;
      l = l_in;
      if (b < k) begin
         diff = k - b;
         b = k;
         if (l < diff) begin
            l = '0;
            return;
         end
         l = l - diff;
      end
      if ((b & msa_pkg::PAGE_MASK) != 0 || (l & msa_pkg::PAGE_MASK) != 0) begin
         if (t == msa_pkg::TYPE_RAM) begin
            diff = (64'h1000 - (b & msa_pkg::PAGE_MASK)) & msa_pkg::PAGE_MASK;
            b = (b + msa_pkg::PAGE_MASK) & ~msa_pkg::PAGE_MASK;
            l = (l >= diff) ? l - diff : 64'd0;
            l = l & ~msa_pkg::PAGE_MASK;
         end else begin
            diff = b & msa_pkg::PAGE_MASK;
            b = b & ~msa_pkg::PAGE_MASK;
            if (l > 64'hffff_ffff_ffff_ffff - diff - msa_pkg::PAGE_MASK)
               l = ~msa_pkg::PAGE_MASK;
            else
               l = (l + diff + msa_pkg::PAGE_MASK) & ~msa_pkg::PAGE_MASK;
         end
      end
   endfunction

   task automatic store_region(input msa_pkg::rec_type r);
      int pos;
      pos = 0;
      if (map_count >= MAX_RECORDS) begin
         dropped++;
         return;
      end
      while (pos < map_count && sorted_map[pos].base <= r.base)
         pos++;
      for (int i = map_count; i > pos; i--)
         sorted_map[i] = sorted_map[i - 1];
      sorted_map[pos] = r;
      map_count++;
   endtask

   task automatic emit_map();
      fixed_region_type f;
      logic [63:0] b;
      logic [63:0] l;
      for (int i = 0; i < map_count; i++) begin
         align_region(sorted_map[i].base, sorted_map[i].length, sorted_map[i].rtype,
                      kernel_end, b, l);
         f.base = b;
         f.length = l;
         f.rtype = sorted_map[i].rtype;
         f.attr = sorted_map[i].attr;
         f.usable = 1'b0;
         f.usable_length = '0;
         if (f.rtype == msa_pkg::TYPE_RAM && l != 0 && b <= msa_pkg::LIMIT32) begin
            f.usable = 1'b1;
            f.usable_length = (l > msa_pkg::LIMIT32 - b) ? 32'(msa_pkg::LIMIT32 - b)
                                                         : 32'(l);
         end
         f.run_end = (i + 1 == map_count);
         fixed_regions.push_back(f);
      end
      map_count = 0;
      maps_done++;
   endtask

   task automatic compare_region();
      fixed_region_type e;
      fixed_region_type a;
      a = '{rsp_out_base, rsp_out_length, rsp_out_type, rsp_out_attr, rsp_usable,
            rsp_usable_length, rsp_run_end};
      if (fixed_regions.size() == 0) begin
         $display("%0t: unexpected region base=%h", $time, a.base);
         failures++;
         return;
      end
      e = fixed_regions.pop_front();
      regions_checked++;
      if (a.base !== e.base) begin
         $display("%0t: base exp %h got %h", $time, e.base, a.base);
         failures++;
      end
      if (a.length !== e.length) begin
         $display("%0t: length exp %h got %h", $time, e.length, a.length);
         failures++;
      end
      if (a.rtype !== e.rtype) begin
         $display("%0t: type exp %h got %h", $time, e.rtype, a.rtype);
         failures++;
      end
      if (a.attr !== e.attr) begin
         $display("%0t: attr exp %h got %h", $time, e.attr, a.attr);
         failures++;
      end
      if (a.usable !== e.usable) begin
         $display("%0t: usable exp %b got %b", $time, e.usable, a.usable);
         failures++;
      end
      if (a.usable_length !== e.usable_length) begin
         $display("%0t: usable_length exp %h got %h", $time, e.usable_length,
                  a.usable_length);
         failures++;
      end
      if (a.run_end !== e.run_end) begin
         $display("%0t: run_end exp %b got %b", $time, e.run_end, a.run_end);
         failures++;
      end
   endtask

   initial begin
      failures = 0;
      regions_checked = 0;
      maps_done = 0;
      dropped = 0;
      map_count = 0;
      kernel_end = msa_pkg::KEND_RESET;
   end

   always @(posedge clock) begin
      if (reset) begin
         map_count = 0;
         kernel_end = msa_pkg::KEND_RESET;
         fixed_regions.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            compare_region();
         if (csr_write)
            kernel_end = csr_kernel_end;
         if (req_valid && req_ready) begin
            store_region('{req_region_base, req_region_length, req_region_type,
                           req_region_attr});
            if (req_is_final)
               emit_map();
         end
      end
   end
endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RECORDS_TB = 32;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [30:0] csr_kernel_end;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_region_base;
   logic [63:0] req_region_length;
   logic [31:0] req_region_type;
   logic [31:0] req_region_attr;
   logic        req_is_final;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_out_base;
   logic [63:0] rsp_out_length;
   logic [31:0] rsp_out_type;
   logic [31:0] rsp_out_attr;
   logic        rsp_usable;
   logic [31:0] rsp_usable_length;
   logic        rsp_run_end;

   int failures, pending, regions_checked, maps_done, dropped;
   int records_sent;
   bit busy_sender;
   bit hold_request;

   memory_map_sort_and_page_align uut (.*);
   memory_map_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int run;
      bit val;
      rsp_ready = 1'b0;
      hold_request = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            val = ($urandom_range(0, 3) != 0);
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 4);
            rsp_ready <= val;
            repeat (run) @(negedge clock);
         end
      end
   end

   function automatic logic [63:0] pick_base();
      case ($urandom_range(0, 5))
         0, 1: return 64'($urandom_range(0, 32'h0030_0000));
         2: return {32'h0, $urandom};
         3: return {$urandom, $urandom};
         4: return 64'hffff_ffff_ffff_f000 + 64'($urandom_range(0, 32'hfff));
         default: return 64'($urandom_range(0, 255)) << 12;
      endcase
   endfunction

   function automatic logic [63:0] pick_length();
      case ($urandom_range(0, 5))
         0, 1: return 64'($urandom_range(0, 32'h0004_0000));
         2: return 64'($urandom_range(0, 1023)) << 12;
         3: return {$urandom, $urandom};
         4: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 32'h1fff));
         default: return {32'h0, $urandom};
      endcase
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_region(input logic [63:0] b, input logic [63:0] l,
                              input logic [31:0] t, input logic [31:0] a, input logic fin);
      int gap;
      req_region_base <= b;
      req_region_length <= l;
      req_region_type <= t;
      req_region_attr <= a;
      req_is_final <= fin;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      records_sent++;
      @(negedge clock);
      gap = 0;
      if (!busy_sender && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random_map(input int n);
      logic [31:0] t;
      logic [63:0] shared;
      shared = pick_base();
      for (int i = 0; i < n; i++) begin
         t = ($urandom_range(0, 2) != 0) ? msa_pkg::TYPE_RAM : $urandom;
         send_region(($urandom_range(0, 5) == 0) ? shared : pick_base(), pick_length(), t,
                     $urandom, i == n - 1);
      end
   endtask

   task automatic set_kernel_end(input logic [30:0] k);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write <= 1'b1;
      csr_kernel_end <= k;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int n;
      logic [30:0] k;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_kernel_end = '0;
      req_valid = 1'b0;
      req_region_base = '0;
      req_region_length = '0;
      req_region_type = '0;
      req_region_attr = '0;
      req_is_final = 1'b0;
      records_sent = 0;
      busy_sender = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset kernel end: consumed, clipped, shrink to zero, grow, equal bases, wrap
      send_region(64'h0, 64'h10, msa_pkg::TYPE_RAM, 32'h0, 1'b0);
      send_region(64'h8_0000, 64'h10_0000, msa_pkg::TYPE_RAM, 32'h1, 1'b0);
      send_region(64'h20_0001, 64'h10, msa_pkg::TYPE_RAM, 32'h2, 1'b0);
      send_region(64'h20_0001, 64'h3000, 32'd2, 32'h3, 1'b0);
      send_region(64'hffff_ffff_ffff_f001, 64'h2000, msa_pkg::TYPE_RAM, 32'h4, 1'b0);
      send_region(64'hffff_ffff_ffff_f001, '1, 32'd5, 32'h5, 1'b0);
      send_region('1, '1, '1, '1, 1'b1);
      send_region('0, '0, '0, '0, 1'b1);

      set_kernel_end('0);
      send_region(64'h1000, 64'h2000, msa_pkg::TYPE_RAM, 32'haaaa_5555, 1'b0);
      send_region(64'hffff_f000, 64'h1_0000, msa_pkg::TYPE_RAM, 32'h5555_aaaa, 1'b0);
      send_region(64'h1_0000_0000, 64'h1000, msa_pkg::TYPE_RAM, 32'h0, 1'b1);

      set_kernel_end(31'h7fff_ffff);
      send_region(64'h7fff_fffe, 64'h1, msa_pkg::TYPE_RAM, 32'h0, 1'b0);
      send_region(64'h7fff_ffff, 64'h10, 32'd2, 32'h0, 1'b0);
      send_region(64'h7000_0000, 64'h2000_0000, msa_pkg::TYPE_RAM, 32'h0, 1'b1);

      set_kernel_end(msa_pkg::KEND_RESET);
      // long receiver hold-off while a map that overflows the store comes in
      hold_request = 1'b1;
      busy_sender = 1'b1;
      send_random_map(MAX_RECORDS_TB + 2);
      send_random_map(3);
      busy_sender = 1'b0;

      for (int m = 0; records_sent < 200; m++) begin
         if (m % 6 == 5) begin
            case ($urandom_range(0, 3))
               0: k = '0;
               1: k = 31'h7fff_ffff;
               2: k = msa_pkg::KEND_RESET;
               default: k = 31'($urandom_range(0, 32'h0040_0000));
            endcase
            set_kernel_end(k);
         end
         busy_sender = ($urandom_range(0, 3) == 0);
         n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
         send_random_map(n);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d records in, %0d maps, %0d regions checked, %0d dropped on a full store",
               records_sent, maps_done, regions_checked, dropped);
      $display("kernel end set to zero, max and reset value; receiver hold-off exercised");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
sv/msa_pkg.sv
sv/msa_sorter.sv
sv/msa_fixer.sv
sv/memory_map_sort_and_page_align.sv
dv/memory_map_checker.sv
dv/testbench.sv
